[hw/rtl/second_chance_page_replacer_assert.svh]
// Assertion shorthands for the replacer's RTL.
`ifndef SECOND_CHANCE_PAGE_REPLACER_ASSERT_SVH
`define SECOND_CHANCE_PAGE_REPLACER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCPR_ASSERT_SAME(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCPR_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/scpr_pkg.sv]
`default_nettype none

package scpr_pkg;

    localparam int FrameBits  = 6;
    localparam int FrameCount = 2 ** FrameBits;
    localparam int ModeBits   = 2;
    localparam int StatusBits = 2;

    localparam logic [ModeBits-1:0] MODE_INSERT  = 2'd0;
    localparam logic [ModeBits-1:0] MODE_TOUCH   = 2'd1;
    localparam logic [ModeBits-1:0] MODE_REPLACE = 2'd2;

    localparam logic [StatusBits-1:0] STATUS_OK    = 2'd0;
    localparam logic [StatusBits-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [StatusBits-1:0] STATUS_FULL  = 2'd2;

    // Broadcast to every cell of the ring.
    typedef struct packed {
        logic insert;
        logic rotate;
        logic pop;
    } cell_ctrl_t;

    // Write port of the referenced-bit store.
    typedef struct packed {
        logic                 en;
        logic [FrameBits-1:0] frame;
        logic                 val;
    } ref_wr_t;

endpackage

`default_nettype wire

[hw/rtl/second_chance_page_replacer.sv]
// Insert, touch, no-op and replace on an empty ring: result in the cycle after the transfer,
// and a new command may be started in that same cycle (one command per cycle while not busy).
// Replace: the walk rotates each referenced entry to the tail, at most the entry count of
// them, one per cycle through the row of cells, and then pops the unreferenced head as the victim.
// Results are strobed by done for one cycle; the receiver cannot stall them.
// Reset clears the control state and all referenced bits at once; ring contents are not reset.
`default_nettype none

module second_chance_page_replacer
    import scpr_pkg::*;
#(
    parameter int NUM_FRAMES = 64,
    parameter int PID_BITS   = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [ModeBits-1:0]   mode,
    input  wire logic [PID_BITS-1:0]   owner_pid,
    input  wire logic [FrameBits-1:0]  frame_number,
    input  wire logic                  initial_ref,
    output logic                       done,
    output logic      [StatusBits-1:0] status,
    output logic      [PID_BITS-1:0]   victim_pid,
    output logic      [FrameBits-1:0]  victim_frame
);

`include "second_chance_page_replacer_assert.svh"

    localparam int CntBits = $clog2(NUM_FRAMES + 1);
    localparam logic [CntBits-1:0] CntFull = CntBits'(NUM_FRAMES);

    typedef enum logic {ST_IDLE, ST_WALK} state_t;

    state_t               state_reg, state_next;
    logic [CntBits-1:0]   count_reg, count_next;
    logic                 done_reg, done_next;
    logic [StatusBits-1:0] status_reg, status_next;
    logic [PID_BITS-1:0]  vpid_reg, vpid_next;
    logic [FrameBits-1:0] vframe_reg, vframe_next;

    cell_ctrl_t ctrl;
    ref_wr_t    ref_wr;
    logic       head_ref;
    logic       accept;

    logic [PID_BITS-1:0]  cell_pid   [NUM_FRAMES];
    logic [FrameBits-1:0] cell_frame [NUM_FRAMES];

    // Cell 0 is always the head of the ring; the last cell's neighbour input is unused
    // in practice and is tied to the head.
    for (genvar g = 0; g < NUM_FRAMES; g++)
    begin : g_cell
        localparam int Nb = (g + 1 < NUM_FRAMES) ? g + 1 : 0;
        scpr_cell #(
            .PID_BITS (PID_BITS),
            .CNT_BITS (CntBits),
            .INDEX    (g)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .head_pid   (cell_pid[0]),
            .head_frame (cell_frame[0]),
            .next_pid   (cell_pid[Nb]),
            .next_frame (cell_frame[Nb]),
            .new_pid    (owner_pid),
            .new_frame  (frame_number),
            .pid        (cell_pid[g]),
            .frame      (cell_frame[g])
        );
    end

    scpr_ref_bits #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_ref_bits (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (ref_wr),
        .rd_frame (cell_frame[0]),
        .rd_bit   (head_ref)
    );

    assign busy   = (state_reg == ST_WALK);
    assign accept = start && !busy;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        status_next  = STATUS_OK;
        vpid_next    = '0;
        vframe_next  = '0;
        ctrl         = '0;
        ref_wr.en    = 1'b0;
        ref_wr.frame = frame_number;
        ref_wr.val   = initial_ref;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    unique case (mode)
                        MODE_INSERT:
                        begin
                            if (count_reg == CntFull)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                ctrl.insert = 1'b1;
                                ref_wr.en   = 1'b1;
                                count_next  = count_reg + CntBits'(1);
                            end
                        end
                        MODE_TOUCH:
                        begin
                            ref_wr.en  = 1'b1;
                            ref_wr.val = 1'b1;
                        end
                        MODE_REPLACE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = ST_WALK;
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (head_ref)
                begin
                    // Second chance: clear the bit and send the head to the tail.
                    ref_wr.en    = 1'b1;
                    ref_wr.frame = cell_frame[0];
                    ref_wr.val   = 1'b0;
                    ctrl.rotate  = 1'b1;
                end
                else
                begin
                    ctrl.pop    = 1'b1;
                    count_next  = count_reg - CntBits'(1);
                    done_next   = 1'b1;
                    vpid_next   = cell_pid[0];
                    vframe_next = cell_frame[0];
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= STATUS_OK;
            vpid_reg   <= '0;
            vframe_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            vpid_reg   <= vpid_next;
            vframe_reg <= vframe_next;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign victim_pid   = vpid_reg;
    assign victim_frame = vframe_reg;

    `SCPR_ASSERT_SAME(a_count_max, clk, rst_n, 1'b1, count_reg <= CntFull,
        "entry count exceeds the ring size")
    `SCPR_ASSERT_SAME(a_walk_nonempty, clk, rst_n, state_reg == ST_WALK, count_reg != '0,
        "replacement walk on an empty ring")
    `SCPR_ASSERT_NEXT(a_replace_walks, clk, rst_n,
        accept && (mode == MODE_REPLACE) && (count_reg != '0), busy && !done,
        "replace on a non-empty ring did not start a walk")
    `SCPR_ASSERT_NEXT(a_pop_result, clk, rst_n, (state_reg == ST_WALK) && !head_ref,
        done && (status == STATUS_OK) && !busy,
        "victim removal did not give an ok result")
    `SCPR_ASSERT_SAME(a_no_done_walking, clk, rst_n, busy, !done,
        "result strobed while a walk is in progress")

endmodule

`default_nettype wire

[hw/rtl/scpr_cell.sv]
`default_nettype none

module scpr_cell
    import scpr_pkg::*;
#(
    parameter int PID_BITS = 16,
    parameter int CNT_BITS = 7,
    parameter int INDEX    = 0
)
(
    input  wire logic                 clk,
    input  wire cell_ctrl_t           ctrl,
    input  wire logic [CNT_BITS-1:0]  count,
    input  wire logic [PID_BITS-1:0]  head_pid,
    input  wire logic [FrameBits-1:0] head_frame,
    input  wire logic [PID_BITS-1:0]  next_pid,
    input  wire logic [FrameBits-1:0] next_frame,
    input  wire logic [PID_BITS-1:0]  new_pid,
    input  wire logic [FrameBits-1:0] new_frame,
    output logic      [PID_BITS-1:0]  pid,
    output logic      [FrameBits-1:0] frame
);

    localparam logic [CNT_BITS-1:0] MyIdx   = CNT_BITS'(INDEX);
    localparam logic [CNT_BITS-1:0] MyIdxP1 = CNT_BITS'(INDEX + 1);

    logic [PID_BITS-1:0]  pid_reg;
    logic [FrameBits-1:0] frame_reg;

    // Insert fills the cell past the live tail; on a rotation the live tail takes the
    // old head, and every other cell takes its right-hand neighbour whenever the ring moves.
    always_ff @(posedge clk)
    begin
        priority if (ctrl.insert && (count == MyIdx))
        begin
            pid_reg   <= new_pid;
            frame_reg <= new_frame;
        end
        else if (ctrl.rotate && (count == MyIdxP1))
        begin
            pid_reg   <= head_pid;
            frame_reg <= head_frame;
        end
        else if (ctrl.rotate || ctrl.pop)
        begin
            pid_reg   <= next_pid;
            frame_reg <= next_frame;
        end
        else
        begin
            pid_reg   <= pid_reg;
            frame_reg <= frame_reg;
        end
    end

    assign pid   = pid_reg;
    assign frame = frame_reg;

endmodule

`default_nettype wire

[hw/rtl/scpr_ref_bits.sv]
`default_nettype none

module scpr_ref_bits
    import scpr_pkg::*;
#(
    parameter int NUM_FRAMES = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ref_wr_t              wr,
    input  wire logic [FrameBits-1:0] rd_frame,
    output logic                      rd_bit
);

    // Only frame numbers below FrameCount ever arrive, so no more bits exist.
    localparam int RefDepth = (NUM_FRAMES < FrameCount) ? NUM_FRAMES : FrameCount;
    localparam int SlotBits = $clog2(RefDepth);

    logic [SlotBits-1:0] slot_tab [FrameCount];
    logic [RefDepth-1:0] bits_reg;
    logic [SlotBits-1:0] wr_slot;
    logic [SlotBits-1:0] rd_slot;

    for (genvar g = 0; g < FrameCount; g++)
    begin : g_slot
        localparam int SlotVal = g % NUM_FRAMES;
        assign slot_tab[g] = SlotBits'(SlotVal);
    end

    assign wr_slot = slot_tab[wr.frame];
    assign rd_slot = slot_tab[rd_frame];
    assign rd_bit  = bits_reg[rd_slot];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
        end
        else if (wr.en)
        begin
            bits_reg[wr_slot] <= wr.val;
        end
    end

endmodule

`default_nettype wire

[verif/tb_top.sv]
`default_nettype none

module tb_top
    import scpr_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PidBits = 16;
    localparam int CycleLimit = 1000000;
    localparam logic [ModeBits-1:0] MODE_NOP = 2'd3;

    typedef struct packed {
        logic [StatusBits-1:0] status;
        logic [PidBits-1:0]    pid;
        logic [FrameBits-1:0]  frame;
    } outcome_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [ModeBits-1:0]   mode = '0;
    logic [PidBits-1:0]    owner_pid = '0;
    logic [FrameBits-1:0]  frame_number = '0;
    logic                  initial_ref = 1'b0;
    logic                  busy;
    logic                  done;
    logic [StatusBits-1:0] status;
    logic [PidBits-1:0]    victim_pid;
    logic [FrameBits-1:0]  victim_frame;

    // Shadow copy of the ring, kept in step with every accepted transfer.
    logic [PidBits-1:0]   ring_pid [FrameCount];
    logic [FrameBits-1:0] ring_frm [FrameCount];
    logic                 ref_bit  [FrameCount];
    logic [FrameBits-1:0] ring_head;
    int                   ring_count;

    outcome_t pending_outcomes[$];
    outcome_t oldest;
    int       idle_pct;
    int       errors;
    int       cycle_count;

    second_chance_page_replacer #(
        .NUM_FRAMES (FrameCount),
        .PID_BITS   (PidBits)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .owner_pid    (owner_pid),
        .frame_number (frame_number),
        .initial_ref  (initial_ref),
        .done         (done),
        .status       (status),
        .victim_pid   (victim_pid),
        .victim_frame (victim_frame)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic outcome_t apply_page_op(input logic [ModeBits-1:0] op,
                                               input logic [PidBits-1:0] pid,
                                               input logic [FrameBits-1:0] frm,
                                               input logic iref);
        outcome_t             res;
        int                   steps;
        logic [FrameBits-1:0] tl;
        logic                 walking;
        res = '0;
        case (op)
            MODE_INSERT:
            begin
                if (ring_count >= FrameCount)
                    res.status = STATUS_FULL;
                else
                begin
                    tl = ring_head + ring_count[FrameBits-1:0];
                    ring_pid[tl] = pid;
                    ring_frm[tl] = frm;
                    ref_bit[frm] = iref;
                    ring_count++;
                end
            end
            MODE_TOUCH:
                ref_bit[frm] = 1'b1;
            MODE_REPLACE:
            begin
                if (ring_count == 0)
                    res.status = STATUS_EMPTY;
                else
                begin
                    // Referenced entries lose their bit and go round to the tail.
                    steps = 0;
                    walking = 1'b1;
                    while (walking && steps <= ring_count)
                    begin
                        if (!ref_bit[ring_frm[ring_head]])
                            walking = 1'b0;
                        else
                        begin
                            ref_bit[ring_frm[ring_head]] = 1'b0;
                            tl = ring_head + ring_count[FrameBits-1:0];
                            ring_pid[tl] = ring_pid[ring_head];
                            ring_frm[tl] = ring_frm[ring_head];
                            ring_head = ring_head + 1'b1;
                            steps++;
                        end
                    end
                    res.pid = ring_pid[ring_head];
                    res.frame = ring_frm[ring_head];
                    ring_head = ring_head + 1'b1;
                    ring_count--;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic send_cmd(input logic [ModeBits-1:0] op, input logic [PidBits-1:0] pid,
                            input logic [FrameBits-1:0] frm, input logic iref);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        mode <= op;
        owner_pid <= pid;
        frame_number <= frm;
        initial_ref <= iref;
        do
            @(posedge clk);
        while (busy);
        pending_outcomes.push_back(apply_page_op(op, pid, frm, iref));
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result status %0d pid %0h frame %0d",
                         $time, status, victim_pid, victim_frame);
                errors++;
            end
            else
            begin
                oldest = pending_outcomes.pop_front();
                if (status !== oldest.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, oldest.status, status);
                    errors++;
                end
                if (victim_pid !== oldest.pid)
                begin
                    $display("%0t: victim_pid expected %0h actual %0h",
                             $time, oldest.pid, victim_pid);
                    errors++;
                end
                if (victim_frame !== oldest.frame)
                begin
                    $display("%0t: victim_frame expected %0d actual %0d",
                             $time, oldest.frame, victim_frame);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic test_empty_ring();
        send_cmd(MODE_REPLACE, 16'h5a5a, 6'd7, 1'b1);
        send_cmd(MODE_NOP, 16'hffff, 6'd63, 1'b1);
        send_cmd(MODE_REPLACE, 16'h0000, 6'd0, 1'b0);
        settle();
    endtask

    task automatic test_insert_extremes();
        send_cmd(MODE_INSERT, 16'h0000, 6'd0, 1'b0);
        send_cmd(MODE_INSERT, 16'hffff, 6'd63, 1'b1);
        send_cmd(MODE_INSERT, 16'h1234, 6'd5, 1'b0);
        send_cmd(MODE_REPLACE, 16'h0000, 6'd0, 1'b0);
        send_cmd(MODE_REPLACE, 16'hffff, 6'd63, 1'b1);
        // Removing the last entry leaves the ring empty, so the final replace fails.
        send_cmd(MODE_REPLACE, 16'h0000, 6'd0, 1'b0);
        send_cmd(MODE_REPLACE, 16'h0000, 6'd0, 1'b0);
        settle();
    endtask

    task automatic test_touch_and_shared_bits();
        // A touch of a frame that is not resident still sets its bit; the insert overwrites it.
        send_cmd(MODE_TOUCH, 16'h0000, 6'd9, 1'b0);
        send_cmd(MODE_INSERT, 16'h0909, 6'd9, 1'b0);
        send_cmd(MODE_INSERT, 16'haaaa, 6'd12, 1'b0);
        send_cmd(MODE_INSERT, 16'h5555, 6'd12, 1'b0);
        send_cmd(MODE_TOUCH, 16'hffff, 6'd12, 1'b1);
        send_cmd(MODE_REPLACE, 16'h0000, 6'd0, 1'b0);
        send_cmd(MODE_REPLACE, 16'h0000, 6'd0, 1'b0);
        send_cmd(MODE_TOUCH, 16'h0000, 6'd12, 1'b0);
        send_cmd(MODE_REPLACE, 16'h0000, 6'd0, 1'b0);
        send_cmd(MODE_REPLACE, 16'h0000, 6'd0, 1'b0);
        settle();
    endtask

    task automatic test_full_ring();
        int i;
        for (i = 0; i < FrameCount; i++)
            send_cmd(MODE_INSERT, 16'($urandom), 6'(i), 1'b1);
        send_cmd(MODE_INSERT, 16'hffff, 6'd63, 1'b1);
        // Every bit is set, so this replace goes round the whole ring once.
        send_cmd(MODE_REPLACE, 16'h0000, 6'd0, 1'b0);
        send_cmd(MODE_INSERT, 16'h8001, 6'd33, 1'b1);
        send_cmd(MODE_INSERT, 16'h7ffe, 6'd34, 1'b0);
        for (i = 0; i <= FrameCount; i++)
        begin
            if (i % 9 == 0)
                send_cmd(MODE_TOUCH, 16'h0000, 6'($urandom_range(0, 63)), 1'b0);
            send_cmd(MODE_REPLACE, 16'($urandom), 6'($urandom), 1'($urandom));
        end
        settle();
    endtask

    task automatic test_random_traffic(input int items, input int pct);
        int               n;
        int               r;
        int               ins_weight;
        logic [FrameBits-1:0] frm;
        logic [ModeBits-1:0]  op;
        idle_pct = pct;
        ins_weight = 40;
        for (n = 0; n < items; n++)
        begin
            // The mix drifts so that the ring fills up and drains in turn.
            if (n % 40 == 0)
                ins_weight = $urandom_range(15, 65);
            r = $urandom_range(0, 99);
            if (r < 3)
                op = MODE_NOP;
            else if (r < 3 + ins_weight)
                op = MODE_INSERT;
            else if (r < 23 + ins_weight)
                op = MODE_TOUCH;
            else
                op = MODE_REPLACE;
            if ($urandom_range(0, 1) == 0)
                frm = 6'($urandom_range(0, 7));
            else
                frm = 6'($urandom_range(0, 63));
            if (op == MODE_TOUCH && ring_count > 0 && $urandom_range(0, 9) < 6)
                frm = ring_frm[ring_head + FrameBits'($urandom_range(0, ring_count - 1))];
            send_cmd(op, 16'($urandom), frm, 1'($urandom));
        end
        settle();
    endtask

    initial
    begin
        errors = 0;
        cycle_count = 0;
        idle_pct = 0;
        ring_head = '0;
        ring_count = 0;
        ring_pid = '{default: '0};
        ring_frm = '{default: '0};
        ref_bit = '{default: 1'b0};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_pct = 31;
        test_empty_ring();
        test_insert_extremes();
        test_touch_and_shared_bits();
        test_full_ring();
        test_random_traffic(460, 31);
        test_random_traffic(460, 86);
        test_random_traffic(460, 0);
        repeat (80) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
+incdir+hw/rtl
hw/rtl/scpr_pkg.sv
hw/rtl/scpr_cell.sv
hw/rtl/scpr_ref_bits.sv
hw/rtl/second_chance_page_replacer.sv
verif/tb_top.sv
